>>> sv/spq_pkg.sv
// shared types, sizes and codes for the sorted priority queue
package spq_pkg;

    localparam int DEPTH    = 128;
    localparam int TAG_BITS = 16;
    localparam int KEY_W    = 16;
    localparam int POS_W    = 7;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int GRP      = 16;
    localparam int NGRP     = (DEPTH + GRP - 1) / GRP;

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_OUT  = 1'b1
    } t_state;

    // broadcast to every cell in the cycle a beat is taken
    typedef struct packed {
        logic ins;
        logic rem;
        t_key key;
        t_tag tag;
    } t_cell_ctl;

endpackage

>>> sv/sorted_array_priority_queue_top.sv
// top level of the sorted-insertion priority queue
//
// Keeps up to DEPTH entries (16-bit key plus tag) sorted by ascending key in a
// chain of cells. A request beat is taken on a rising edge with start high and
// busy low. An insert compares its key in every cell at once and the cells
// from the insertion point on shift one place tailward; equal keys stay
// behind the new entry. A remove takes the entry at i_position and the cells
// behind it shift one place headward.
// Each request gives one result beat, shown for one cycle with o_done high,
// in the cycle after the request edge; busy is high during that cycle, so no
// request is taken while a result is out. The removed entry is picked from
// the cells through a registered two-level mux.
// Status reports a full store (insert dropped) or an unoccupied position
// (nothing changes); o_count gives the entry count after the request.
// Reset empties the queue at once; no clearing pass is needed.
// The receiver cannot stall; each result is there for exactly one cycle.
module sorted_array_priority_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [15:0] i_new_key,
    input  logic [15:0] i_new_tag,
    input  logic [6:0]  i_position,
    output logic        o_done,
    output logic [15:0] o_out_key,
    output logic [15:0] o_out_tag,
    output logic [1:0]  o_status,
    output logic [7:0]  o_count
);

    spq_pkg::t_state    r_state, n_state;
    spq_pkg::t_cnt      r_count, n_count;
    spq_pkg::t_status   r_status, n_status;
    spq_pkg::t_cell_ctl ctl;

    logic          take;
    logic          full;
    logic          bad_pos;
    logic          ins_ok;
    logic          rem_ok;
    spq_pkg::t_cnt pos_ext;

    logic          ge     [spq_pkg::DEPTH];
    logic          hit    [spq_pkg::DEPTH];
    spq_pkg::t_key c_key  [spq_pkg::DEPTH];
    spq_pkg::t_tag c_tag  [spq_pkg::DEPTH];
    spq_pkg::t_key g_key;
    spq_pkg::t_tag g_tag;

    assign busy    = (r_state == spq_pkg::S_OUT);
    assign take    = start && !busy;
    assign pos_ext = spq_pkg::t_cnt'(i_position);
    assign full    = (r_count == spq_pkg::t_cnt'(spq_pkg::DEPTH));
    assign bad_pos = (pos_ext >= r_count);
    assign ins_ok  = take && (i_req_type == spq_pkg::REQ_INSERT) && !full;
    assign rem_ok  = take && (i_req_type == spq_pkg::REQ_REMOVE) && !bad_pos;

    assign ctl.ins = ins_ok;
    assign ctl.rem = rem_ok;
    assign ctl.key = i_new_key;
    assign ctl.tag = i_new_tag[spq_pkg::TAG_BITS-1:0];

    for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
        logic          occ;
        logic          prev_ge;
        spq_pkg::t_key prev_key;
        spq_pkg::t_tag prev_tag;
        spq_pkg::t_key next_key;
        spq_pkg::t_tag next_tag;

        assign occ    = (spq_pkg::t_cnt'(i) < r_count);
        assign hit[i] = rem_ok && (spq_pkg::t_cnt'(i) == pos_ext);

        if (i == 0) begin : g_head
            assign prev_ge  = 1'b0;
            assign prev_key = '0;
            assign prev_tag = '0;
        end else begin : g_body
            assign prev_ge  = ge[i-1];
            assign prev_key = c_key[i-1];
            assign prev_tag = c_tag[i-1];
        end

        if (i == spq_pkg::DEPTH - 1) begin : g_tail
            assign next_key = '0;
            assign next_tag = '0;
        end else begin : g_mid
            assign next_key = c_key[i+1];
            assign next_tag = c_tag[i+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_occ      (occ),
            .i_shift_up (spq_pkg::t_cnt'(i) >= pos_ext),
            .i_prev_ge  (prev_ge),
            .i_prev_key (prev_key),
            .i_prev_tag (prev_tag),
            .i_next_key (next_key),
            .i_next_tag (next_tag),
            .o_ge       (ge[i]),
            .o_key      (c_key[i]),
            .o_tag      (c_tag[i])
        );
    end

    spq_gather u_gather (
        .i_clk  (i_clk),
        .i_load (take),
        .i_hit  (hit),
        .i_key  (c_key),
        .i_tag  (c_tag),
        .o_key  (g_key),
        .o_tag  (g_tag)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = r_status;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (take) begin
                    n_state = spq_pkg::S_OUT;
                    if (i_req_type == spq_pkg::REQ_INSERT) begin
                        n_status = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
                    end else begin
                        n_status = bad_pos ? spq_pkg::ST_BADPOS : spq_pkg::ST_OK;
                    end
                    if (ins_ok) begin
                        n_count = r_count + 1'b1;
                    end else if (rem_ok) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            spq_pkg::S_OUT: begin
                n_state = spq_pkg::S_IDLE;
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spq_pkg::S_IDLE;
            r_count  <= '0;
            r_status <= spq_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    assign o_done    = (r_state == spq_pkg::S_OUT);
    assign o_out_key = g_key;
    assign o_out_tag = 16'(g_tag);
    assign o_status  = r_status;
    assign o_count   = 8'(r_count);

endmodule

>>> sv/spq_cell.sv
// one storage cell of the sorted chain: holds an entry and shifts with its neighbors
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic              i_occ,
    input  logic              i_shift_up,
    input  logic              i_prev_ge,
    input  spq_pkg::t_key     i_prev_key,
    input  spq_pkg::t_tag     i_prev_tag,
    input  spq_pkg::t_key     i_next_key,
    input  spq_pkg::t_tag     i_next_tag,
    output logic              o_ge,
    output spq_pkg::t_key     o_key,
    output spq_pkg::t_tag     o_tag
);

    spq_pkg::t_key r_key, n_key;
    spq_pkg::t_tag r_tag, n_tag;

    // empty cells count as not smaller, so the first free slot takes the entry
    assign o_ge = !i_occ || (r_key >= i_ctl.key);

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.ins && o_ge) begin
            if (i_prev_ge) begin
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end else begin
                n_key = i_ctl.key;
                n_tag = i_ctl.tag;
            end
        end else if (i_ctl.rem && i_shift_up) begin
            n_key = i_next_key;
            n_tag = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

>>> sv/spq_gather.sv
// two-level registered pick of the selected cell's entry
module spq_gather (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_hit [spq_pkg::DEPTH],
    input  spq_pkg::t_key i_key [spq_pkg::DEPTH],
    input  spq_pkg::t_tag i_tag [spq_pkg::DEPTH],
    output spq_pkg::t_key o_key,
    output spq_pkg::t_tag o_tag
);

    spq_pkg::t_key r_gkey [spq_pkg::NGRP];
    spq_pkg::t_tag r_gtag [spq_pkg::NGRP];
    spq_pkg::t_key n_gkey [spq_pkg::NGRP];
    spq_pkg::t_tag n_gtag [spq_pkg::NGRP];

    // at most one hit, so an and-or per group is a mux
    always_comb begin
        for (int g = 0; g < spq_pkg::NGRP; g++) begin
            n_gkey[g] = '0;
            n_gtag[g] = '0;
            for (int j = 0; j < spq_pkg::GRP; j++) begin
                if (g * spq_pkg::GRP + j < spq_pkg::DEPTH) begin
                    if (i_hit[g * spq_pkg::GRP + j]) begin
                        n_gkey[g] = n_gkey[g] | i_key[g * spq_pkg::GRP + j];
                        n_gtag[g] = n_gtag[g] | i_tag[g * spq_pkg::GRP + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gkey <= n_gkey;
            r_gtag <= n_gtag;
        end
    end

    always_comb begin
        o_key = '0;
        o_tag = '0;
        for (int g = 0; g < spq_pkg::NGRP; g++) begin
            o_key = o_key | r_gkey[g];
            o_tag = o_tag | r_gtag[g];
        end
    end

endmodule

>>> sv/spq_checker.sv
// port-level checks for the priority queue, bound to the top level
module spq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        o_done,
    input  logic [15:0] o_out_key,
    input  logic [15:0] o_out_tag,
    input  logic [1:0]  o_status,
    input  logic [7:0]  o_count
);

    // every taken beat answers on the next cycle
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_done)
        else $error("request beat without result beat");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // errors carry no entry
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != 2'(spq_pkg::ST_OK)) |-> (o_out_key == '0) && (o_out_tag == '0))
        else $error("error result with nonzero entry");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == 2'(spq_pkg::ST_FULL)) |-> o_count == 8'(spq_pkg::DEPTH))
        else $error("full status with store not full");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_count <= 8'(spq_pkg::DEPTH))
        else $error("count beyond depth");

endmodule

bind sorted_array_priority_queue_top spq_checker u_spq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_done    (o_done),
    .o_out_key (o_out_key),
    .o_out_tag (o_out_tag),
    .o_status  (o_status),
    .o_count   (o_count)
);

>>> test/tb_sorted_array_priority_queue_top.sv
// testbench for the sorted-insertion priority queue: shadow-queue prediction and result checks
`timescale 1ns / 100ps

module tb_sorted_array_priority_queue_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 950;

    typedef struct {
        spq_pkg::t_req kind;
        spq_pkg::t_key key;
        spq_pkg::t_tag tag;
        logic [6:0]    pos;
        bit            drain_first;
    } t_request;

    typedef struct {
        spq_pkg::t_key    key;
        spq_pkg::t_tag    tag;
        spq_pkg::t_status st;
        logic [7:0]       cnt;
        bit               removed;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        i_req_type = 1'b0;
    logic [15:0] i_new_key = '0;
    logic [15:0] i_new_tag = '0;
    logic [6:0]  i_position = '0;
    logic        busy;
    logic        o_done;
    logic [15:0] o_out_key;
    logic [15:0] o_out_tag;
    logic [1:0]  o_status;
    logic [7:0]  o_count;

    sorted_array_priority_queue_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_new_key  (i_new_key),
        .i_new_tag  (i_new_tag),
        .i_position (i_position),
        .o_done     (o_done),
        .o_out_key  (o_out_key),
        .o_out_tag  (o_out_tag),
        .o_status   (o_status),
        .o_count    (o_count)
    );

    // shadow copy of the sorted store
    spq_pkg::t_key shadow_keys [spq_pkg::DEPTH];
    spq_pkg::t_tag shadow_tags [spq_pkg::DEPTH];
    int   shadow_count = 0;

    t_request request_backlog[$];
    t_reply   pending_replies[$];

    int gen_count = 0;
    int err_count = 0;
    int beats_taken = 0;
    int replies_seen = 0;
    int full_seen = 0;
    int badpos_seen = 0;
    int removed_seen = 0;
    int peak_count = 0;
    int gap_left = 0;
    int quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // apply one request to the shadow store and return the reply it must give
    task automatic apply_to_shadow_queue(input t_request rq, output t_reply rp);
        int slot;
        int i;
        rp.key = '0;
        rp.tag = '0;
        rp.st  = spq_pkg::ST_OK;
        rp.removed = 1'b0;
        if (rq.kind == spq_pkg::REQ_INSERT) begin
            if (shadow_count >= spq_pkg::DEPTH) begin
                rp.st = spq_pkg::ST_FULL;
            end else begin
                slot = 0;
                while (slot < shadow_count && shadow_keys[slot] < rq.key) slot++;
                for (i = shadow_count; i > slot; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_tags[i] = shadow_tags[i-1];
                end
                shadow_keys[slot] = rq.key;
                shadow_tags[slot] = rq.tag;
                shadow_count++;
            end
        end else begin
            if (int'(rq.pos) >= shadow_count) begin
                rp.st = spq_pkg::ST_BADPOS;
            end else begin
                rp.key = shadow_keys[rq.pos];
                rp.tag = shadow_tags[rq.pos];
                rp.removed = 1'b1;
                for (i = rq.pos; i + 1 < shadow_count; i++) begin
                    shadow_keys[i] = shadow_keys[i+1];
                    shadow_tags[i] = shadow_tags[i+1];
                end
                shadow_count--;
            end
        end
        rp.cnt = shadow_count[7:0];
    endtask

    task automatic add_insert(input spq_pkg::t_key key, input spq_pkg::t_tag tag,
                              input bit drain_first);
        t_request rq;
        rq.kind = spq_pkg::REQ_INSERT;
        rq.key = key;
        rq.tag = tag;
        rq.pos = 7'($urandom_range(0, 127));
        rq.drain_first = drain_first;
        request_backlog.push_back(rq);
        if (gen_count < spq_pkg::DEPTH) gen_count++;
    endtask

    task automatic add_remove(input logic [6:0] pos, input bit drain_first);
        t_request rq;
        rq.kind = spq_pkg::REQ_REMOVE;
        rq.key = 16'($urandom_range(0, 65535));
        rq.tag = 16'($urandom_range(0, 65535));
        rq.pos = pos;
        rq.drain_first = drain_first;
        request_backlog.push_back(rq);
        if (int'(pos) < gen_count) gen_count--;
    endtask

    // driver: one beat per accepted edge, start held until taken
    always @(posedge i_clk) begin
        t_reply   rp;
        t_request nxt;
        bit       taken;
        bit       may_go;
        bit       idle_on;
        if (i_rst_n) begin
            taken = start && !busy;
            if (taken) begin
                nxt.kind = spq_pkg::t_req'(i_req_type);
                nxt.key = i_new_key;
                nxt.tag = i_new_tag;
                nxt.pos = i_position;
                nxt.drain_first = 1'b0;
                apply_to_shadow_queue(nxt, rp);
                pending_replies.push_back(rp);
                beats_taken++;
                if (shadow_count > peak_count) peak_count = shadow_count;
            end
            if (!start || taken) begin
                // long idle-free stretch in the middle of the run
                idle_on = (beats_taken < 400) || (beats_taken >= 700);
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    // a drain_first beat waits until every reply is back
                    may_go = !request_backlog[0].drain_first
                        || pending_replies.size() == 0
                        || (pending_replies.size() == 1 && o_done && !taken);
                    if (!may_go) begin
                        start <= 1'b0;
                    end else if (idle_on && $urandom_range(0, 99) < 15) begin
                        gap_left = $urandom_range(0, 2);
                        start <= 1'b0;
                    end else begin
                        nxt = request_backlog.pop_front();
                        i_req_type <= nxt.kind;
                        i_new_key  <= nxt.key;
                        i_new_tag  <= nxt.tag;
                        i_position <= nxt.pos;
                        start      <= 1'b1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every done beat is checked against the oldest prediction
    always @(posedge i_clk) begin
        t_reply rp;
        if (i_rst_n && o_done) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected result beat", o_count, 0);
            end else begin
                rp = pending_replies.pop_front();
                if (o_out_key !== rp.key) report_mismatch("out_key", o_out_key, rp.key);
                if (o_out_tag !== rp.tag) report_mismatch("out_tag", o_out_tag, rp.tag);
                if (o_status !== rp.st)   report_mismatch("status", o_status, rp.st);
                if (o_count !== rp.cnt)   report_mismatch("count", o_count, rp.cnt);
                if (rp.st == spq_pkg::ST_FULL) full_seen++;
                if (rp.st == spq_pkg::ST_BADPOS) badpos_seen++;
                if (rp.removed) removed_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int n_rand;
        int mode;
        int len;
        int p_ins;
        int k;
        bit narrow;
        bit hold;
        spq_pkg::t_key key;

        // empty store, equal keys, key and tag extremes, bad positions
        add_remove(7'd0, 1'b0);
        add_remove(7'd127, 1'b0);
        add_insert(16'h8000, 16'hFFFF, 1'b0);
        add_insert(16'hFFFF, 16'h0000, 1'b0);
        add_insert(16'h0000, 16'hAAAA, 1'b0);
        add_insert(16'h8000, 16'h5555, 1'b0);
        add_insert(16'hFFFF, 16'h1234, 1'b0);
        add_remove(7'd5, 1'b0);
        add_remove(7'd1, 1'b0);
        add_remove(7'd3, 1'b0);
        add_remove(7'd0, 1'b0);
        add_remove(7'd0, 1'b0);
        add_remove(7'd0, 1'b0);
        add_remove(7'd0, 1'b0);
        add_insert(16'h1234, 16'hFFFF, 1'b1);
        add_remove(7'd0, 1'b0);

        // fill to the top, overflow, remove the tail, refill and overflow again, then remove the middle
        while (gen_count < spq_pkg::DEPTH)
            add_insert(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
        for (k = 0; k < 4; k++)
            add_insert(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
        add_remove(7'd127, 1'b0);
        add_insert(16'hFFFF, 16'hFFFF, 1'b0);
        add_insert(16'h0000, 16'h0000, 1'b0);
        add_remove(7'd64, 1'b1);

        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(30, 150);
            narrow = $urandom_range(0, 1);
            p_ins = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            for (k = 0; k < len && n_rand < RANDOM_ITEMS; k++) begin
                hold = ($urandom_range(0, 99) == 0) || (k == len - 1);
                key = narrow ? 16'($urandom_range(0, 7) * 16'h2001)
                             : 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 99) < 10) begin
                    // noise: any request, any position
                    if ($urandom_range(0, 1))
                        add_remove(7'($urandom_range(0, 127)), hold);
                    else
                        add_insert(key, 16'($urandom_range(0, 65535)), hold);
                end else if (gen_count == 0 || $urandom_range(0, 99) < p_ins) begin
                    add_insert(key, 16'($urandom_range(0, 65535)), hold);
                end else if ($urandom_range(0, 99) < 30) begin
                    add_remove(7'd0, hold);
                end else begin
                    add_remove(7'($urandom_range(0, gen_count - 1)), hold);
                end
                n_rand++;
            end
        end

        while (!i_rst_n) @(posedge i_clk);
        while (request_backlog.size() != 0 || start || pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d request beats, %0d results: %0d removals, %0d full-store drops, %0d bad positions",
                 beats_taken, replies_seen, removed_seen, full_seen, badpos_seen);
        $display("store occupancy peaked at %0d of %0d entries", peak_count, spq_pkg::DEPTH);
        if (err_count == 0 && pending_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
